### rtl/tcgr_pkg.sv
// tcgr_pkg: shared types and constants of the text console glyph renderer
// used by tcgr_glyph_mem, tcgr_cell_seq and text_console_glyph_renderer
// no dependencies
package tcgr_pkg;

	// fixed field widths
	localparam int GLYPH_BITS = 6;
	localparam int OFFSET_W   = 19;
	localparam int COLOR_W    = 16;
	localparam int CHAR_W     = 8;
	localparam int GLYPH_W    = 7;
	localparam int GROW_W     = 4;
	localparam int COL_W      = 8;
	localparam int ROW_W      = 6;
	localparam int CFG_IDX_W  = 2;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_FIRST   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST    = 8'h7E;

	// register reset values
	localparam logic [COLOR_W-1:0] FG_RESET       = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BG_RESET       = 16'h0000;
	localparam logic [COL_W-1:0]   LAST_COL_RESET = 8'd132;
	localparam logic [ROW_W-1:0]   LAST_ROW_RESET = 6'd59;

	// command codes
	typedef enum logic {
		CMD_DRAW = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOREGROUND  = 2'd0,
		REG_BACKGROUND  = 2'd1,
		REG_LAST_COLUMN = 2'd2,
		REG_LAST_ROW    = 2'd3
	} cfg_reg_t;

	// cell sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DRAW = 1'b1
	} seq_state_t;

	// start of one character cell
	typedef struct packed {
		logic                start;
		logic                blank;
		logic [GLYPH_W-1:0]  glyph;
		logic [OFFSET_W-1:0] base;
	} draw_req_t;

	// sequencer status towards the request side
	typedef struct packed {
		logic busy;
		logic finishing;
	} seq_stat_t;

endpackage

### rtl/tcgr_glyph_mem.sv
// tcgr_glyph_mem: glyph row store, one write port and one registered read port
// depends on tcgr_pkg for the glyph row width
module tcgr_glyph_mem import tcgr_pkg::*; #(
	parameter int DEPTH = 855,
	parameter int AW    = 10
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [GLYPH_BITS-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [GLYPH_BITS-1:0] rd_data
);

	logic [GLYPH_BITS-1:0] mem [DEPTH];
	logic [GLYPH_BITS-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/tcgr_cell_seq.sv
// tcgr_cell_seq: walks one character cell row by row, fetches glyph rows
// from the store and drives the registered pixel output; uses tcgr_pkg
module tcgr_cell_seq import tcgr_pkg::*; #(
	parameter int LINE_STRIDE = 800,
	parameter int CELL_WIDTH  = 6,
	parameter int CELL_HEIGHT = 10,
	parameter int AW          = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  draw_req_t             req,
	output seq_stat_t             stat,
	input  logic [COLOR_W-1:0]    fg,
	input  logic [COLOR_W-1:0]    bg,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  logic [GLYPH_BITS-1:0] rd_data,
	output logic                  pix_valid,
	input  logic                  pix_stall,
	output logic [OFFSET_W-1:0]   pixel_offset,
	output logic [COLOR_W-1:0]    pixel_value,
	output logic                  last_pixel
);

	localparam int GLYPH_ROWS = CELL_HEIGHT - 1;
	localparam int CW_W       = $clog2(CELL_WIDTH);
	localparam int RW_W       = $clog2(CELL_HEIGHT);

	seq_state_t            state_q, state_d;
	logic [CW_W-1:0]       c_q;
	logic [RW_W-1:0]       r_q;
	logic [OFFSET_W-1:0]   row_base_q;
	logic [GLYPH_BITS-1:0] pat_q;
	logic                  blank_q;
	logic [AW-1:0]         gbase_q;
	logic [AW-1:0]         start_gbase;
	logic                  emit;
	logic                  adv;
	logic                  end_of_row;
	logic                  is_last;
	logic [3:0]            bit_idx;
	logic                  pix_bit;

	logic                  pix_valid_q;
	logic [OFFSET_W-1:0]   pixel_offset_q;
	logic [COLOR_W-1:0]    pixel_value_q;
	logic                  last_pixel_q;

	// position within the cell
	assign end_of_row = (c_q == CW_W'(CELL_WIDTH - 1));
	assign is_last    = end_of_row && (r_q == RW_W'(CELL_HEIGHT - 1));
	assign adv        = emit && (!pix_valid_q || !pix_stall);

	// first glyph row of the requested character
	assign start_gbase = AW'(32'(req.glyph) * 32'(GLYPH_ROWS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (adv && is_last && !req.start) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		emit           = 1'b0;
		rd_en          = 1'b0;
		stat.busy      = 1'b0;
		stat.finishing = 1'b0;
		case (state_q)
			ST_IDLE: begin
				emit = 1'b0;
			end
			ST_DRAW: begin
				emit           = 1'b1;
				stat.busy      = 1'b1;
				stat.finishing = adv && is_last;
				// glyph row r feeds cell row r+1, the bottom cell row needs none
				rd_en          = !blank_q && (r_q != RW_W'(CELL_HEIGHT - 1));
			end
			default: emit = 1'b0;
		endcase
	end

	// address held for the whole cell row, data latched at its end
	assign rd_addr = gbase_q + AW'(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// cell counters and glyph pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (req.start) begin
			c_q <= '0;
			r_q <= '0;
		end else if (adv) begin
			if (end_of_row) begin
				c_q <= '0;
				r_q <= r_q + RW_W'(1);
			end else begin
				c_q <= c_q + CW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			row_base_q <= req.base;
			pat_q      <= '0;
			blank_q    <= req.blank;
			gbase_q    <= start_gbase;
		end else if (adv && end_of_row) begin
			row_base_q <= row_base_q + OFFSET_W'(LINE_STRIDE);
			pat_q      <= blank_q ? '0 : rd_data;
		end
	end

	// leftmost pixel is the top bit of the cell width
	assign bit_idx = 4'(CELL_WIDTH - 1) - 4'(c_q);
	assign pix_bit = (bit_idx < 4'(GLYPH_BITS)) ? pat_q[bit_idx[2:0]] : 1'b0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (adv) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_offset_q <= row_base_q + OFFSET_W'(c_q);
			pixel_value_q  <= pix_bit ? fg : bg;
			last_pixel_q   <= is_last;
		end
	end

	assign pix_valid    = pix_valid_q;
	assign pixel_offset = pixel_offset_q;
	assign pixel_value  = pixel_value_q;
	assign last_pixel   = last_pixel_q;

	// a new cell only starts when the previous one is done or finishing
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == ST_IDLE || (adv && is_last)))
		else $error("cell start while a cell is in progress");

	// a start always restarts the walk at the top left pixel
	a_start_resets: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> (state_q == ST_DRAW && c_q == '0 && r_q == '0))
		else $error("cell walk did not restart");

	// the final pixel without a follow-up request returns to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW && adv && is_last && !req.start) |=> state_q == ST_IDLE)
		else $error("sequencer stayed busy after the last pixel");

	// counters stay inside the cell
	a_counters_in_cell: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAW |-> (c_q <= CW_W'(CELL_WIDTH - 1) &&
			r_q <= RW_W'(CELL_HEIGHT - 1)))
		else $error("cell counter out of range");

endmodule

### rtl/text_console_glyph_renderer.sv
// text_console_glyph_renderer: printable byte gives one cell of pixel writes,
// one pixel per cycle while the receiver does not stall, so a printable byte gives
// CELL_WIDTH*CELL_HEIGHT pixel writes (60 by default); the next request can be taken
// in the cycle of the last pixel. Loads, control and other bytes give no pixel writes.
// A printable request loads the sequencer state, then its first pixel the output register.
// Reset clears the cursor and sets the registers to their reset values; the glyph store is undefined until loaded.
module text_console_glyph_renderer import tcgr_pkg::*; #(
	parameter int LINE_STRIDE = 800,
	parameter int CELL_WIDTH  = 6,
	parameter int CELL_HEIGHT = 10,
	parameter int GLYPH_COUNT = 95
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COLOR_W-1:0]    cfg_data,
	// requests
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  command,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [GLYPH_W-1:0]    glyph_number,
	input  logic [GROW_W-1:0]     glyph_row_number,
	input  logic [GLYPH_BITS-1:0] row_bits,
	// pixel writes
	output logic                  pix_valid,
	input  logic                  pix_stall,
	output logic [OFFSET_W-1:0]   pixel_offset,
	output logic [COLOR_W-1:0]    pixel_value,
	output logic                  last_pixel
);

	localparam int GLYPH_ROWS = CELL_HEIGHT - 1;
	localparam int DEPTH      = GLYPH_COUNT * GLYPH_ROWS;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [COLOR_W-1:0]    fg_q, bg_q;
	logic [COL_W-1:0]      last_col_q;
	logic [ROW_W-1:0]      last_row_q;
	logic [COL_W-1:0]      cursor_col_q;
	logic [ROW_W-1:0]      cursor_row_q;

	logic                  accept;
	logic                  is_load;
	logic                  load_ok;
	logic                  is_newline;
	logic                  is_return;
	logic                  is_print;
	logic [GLYPH_W-1:0]    glyph_idx;
	logic [ROW_W-1:0]      row_after_nl;
	logic                  col_wraps;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [GLYPH_BITS-1:0] rd_data;
	draw_req_t             draw_req;
	seq_stat_t             seq_stat;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q       <= FG_RESET;
			bg_q       <= BG_RESET;
			last_col_q <= LAST_COL_RESET;
			last_row_q <= LAST_ROW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FOREGROUND:  fg_q       <= cfg_data;
				REG_BACKGROUND:  bg_q       <= cfg_data;
				REG_LAST_COLUMN: last_col_q <= cfg_data[COL_W-1:0];
				REG_LAST_ROW:    last_row_q <= cfg_data[ROW_W-1:0];
				default:         fg_q       <= fg_q;
			endcase
		end
	end

	// request handshake, held off while a cell is still being drawn
	assign req_stall = seq_stat.busy && !seq_stat.finishing;
	assign accept    = req_valid && !req_stall;

	// request decode
	assign is_load    = (cmd_t'(command) == CMD_LOAD);
	assign load_ok    = ({1'b0, glyph_number} < (GLYPH_W + 1)'(GLYPH_COUNT)) &&
		({1'b0, glyph_row_number} < (GROW_W + 1)'(GLYPH_ROWS));
	assign is_newline = (char_code == CH_NEWLINE);
	assign is_return  = (char_code == CH_RETURN);
	assign is_print   = (char_code >= CH_FIRST) && (char_code <= CH_LAST);
	assign glyph_idx  = GLYPH_W'(char_code - CH_FIRST);

	// glyph row load
	assign wr_en   = accept && is_load && load_ok;
	assign wr_addr = AW'(32'(glyph_number) * 32'(GLYPH_ROWS) + 32'(glyph_row_number));

	// cell start with its top left offset from the current cursor
	assign draw_req.start = accept && !is_load && is_print;
	assign draw_req.blank = !({1'b0, glyph_idx} < (GLYPH_W + 1)'(GLYPH_COUNT));
	assign draw_req.glyph = glyph_idx;
	assign draw_req.base  =
		OFFSET_W'(32'(cursor_row_q) * 32'(CELL_HEIGHT * LINE_STRIDE)) +
		OFFSET_W'(32'(cursor_col_q) * 32'(CELL_WIDTH));

	// cursor movement
	assign row_after_nl = ({1'b0, cursor_row_q} + (ROW_W + 1)'(1) > {1'b0, last_row_q}) ?
		'0 : cursor_row_q + ROW_W'(1);
	assign col_wraps    = ({1'b0, cursor_col_q} + (COL_W + 1)'(1) > {1'b0, last_col_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (accept && !is_load) begin
			if (is_newline) begin
				cursor_col_q <= '0;
				cursor_row_q <= row_after_nl;
			end else if (is_return) begin
				cursor_col_q <= '0;
			end else if (col_wraps) begin
				cursor_col_q <= '0;
				cursor_row_q <= row_after_nl;
			end else begin
				cursor_col_q <= cursor_col_q + COL_W'(1);
			end
		end
	end

	tcgr_glyph_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_glyph_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (row_bits),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tcgr_cell_seq #(
		.LINE_STRIDE (LINE_STRIDE),
		.CELL_WIDTH  (CELL_WIDTH),
		.CELL_HEIGHT (CELL_HEIGHT),
		.AW          (AW)
	) u_cell_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (draw_req),
		.stat         (seq_stat),
		.fg           (fg_q),
		.bg           (bg_q),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pixel_offset (pixel_offset),
		.pixel_value  (pixel_value),
		.last_pixel   (last_pixel)
	);

endmodule

### tb/tb_text_console_glyph_renderer.sv
// tb_text_console_glyph_renderer: self-checking testbench of the text console glyph renderer
// drives font loads and character bytes, predicts every pixel write and compares in order
// depends on tcgr_pkg and text_console_glyph_renderer
`timescale 1ns / 100ps

module tb_text_console_glyph_renderer import tcgr_pkg::*;;

	localparam int LINE_STRIDE = 800;
	localparam int CELL_WIDTH  = 6;
	localparam int CELL_HEIGHT = 10;
	localparam int GLYPH_COUNT = 95;
	localparam int FONT_ROWS   = CELL_HEIGHT - 1;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 8;

	// one request as offered on the input channel
	typedef struct {
		cmd_t                  command;
		logic [CHAR_W-1:0]     char_code;
		logic [GLYPH_W-1:0]    glyph_number;
		logic [GROW_W-1:0]     glyph_row_number;
		logic [GLYPH_BITS-1:0] row_bits;
	} glyph_req_t;

	// one predicted pixel write
	typedef struct {
		logic [OFFSET_W-1:0] offset;
		logic [COLOR_W-1:0]  value;
		logic                last;
	} pixel_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FOREGROUND;
	logic [COLOR_W-1:0]    cfg_data = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic                  command = CMD_DRAW;
	logic [CHAR_W-1:0]     char_code = '0;
	logic [GLYPH_W-1:0]    glyph_number = '0;
	logic [GROW_W-1:0]     glyph_row_number = '0;
	logic [GLYPH_BITS-1:0] row_bits = '0;
	logic                  pix_valid;
	logic                  pix_stall = 1'b0;
	logic [OFFSET_W-1:0]   pixel_offset;
	logic [COLOR_W-1:0]    pixel_value;
	logic                  last_pixel;

	// stimulus side
	glyph_req_t   request_q[$];
	glyph_req_t   offered;
	int           queued_total = 0;
	bit [FONT_ROWS-1:0] gen_rows_loaded [GLYPH_COUNT];
	bit           gen_glyph_ready [GLYPH_COUNT];
	int           ready_glyphs[$];
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	bit           pressure_on = 1'b0;
	bit           hold_done = 1'b0;
	int           hold_left = 0;
	int           cycle_count = 0;
	int           fail_count = 0;

	// predictor state
	pixel_write_t        pixel_writes_q[$];
	logic [COLOR_W-1:0]  fg_color = FG_RESET;
	logic [COLOR_W-1:0]  bg_color = BG_RESET;
	logic [COL_W-1:0]    last_col = LAST_COL_RESET;
	logic [ROW_W-1:0]    last_row = LAST_ROW_RESET;
	logic [COL_W-1:0]    cursor_col = '0;
	logic [ROW_W-1:0]    cursor_row = '0;
	logic [GLYPH_BITS-1:0] font_rows [GLYPH_COUNT*FONT_ROWS];

	text_console_glyph_renderer uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.command          (command),
		.char_code        (char_code),
		.glyph_number     (glyph_number),
		.glyph_row_number (glyph_row_number),
		.row_bits         (row_bits),
		.pix_valid        (pix_valid),
		.pix_stall        (pix_stall),
		.pixel_offset     (pixel_offset),
		.pixel_value      (pixel_value),
		.last_pixel       (last_pixel)
	);

	always #1 clk = ~clk;

	// cursor to column 0 of the next row, wrapping past the last row
	function automatic void next_line();
		cursor_col = '0;
		if (int'(cursor_row) + 1 > int'(last_row))
			cursor_row = '0;
		else
			cursor_row = cursor_row + ROW_W'(1);
	endfunction

	// update cursor and font for one accepted request, queue its pixel writes
	function automatic void render_request(input glyph_req_t q);
		int g;
		int base;
		int off;
		logic [GLYPH_BITS-1:0] pat;
		pixel_write_t p;
		if (q.command == CMD_LOAD) begin
			if (int'(q.glyph_number) < GLYPH_COUNT && int'(q.glyph_row_number) < FONT_ROWS)
				font_rows[int'(q.glyph_number)*FONT_ROWS + int'(q.glyph_row_number)] = q.row_bits;
			return;
		end
		if (q.char_code == CH_NEWLINE) begin
			next_line();
			return;
		end
		if (q.char_code == CH_RETURN) begin
			cursor_col = '0;
			return;
		end
		if (q.char_code >= CH_FIRST && q.char_code <= CH_LAST) begin
			g = int'(q.char_code) - int'(CH_FIRST);
			base = int'(cursor_row)*CELL_HEIGHT*LINE_STRIDE + int'(cursor_col)*CELL_WIDTH;
			for (int r = 0; r < CELL_HEIGHT; r++) begin
				// top row of the cell is always background
				pat = '0;
				if (r > 0 && g < GLYPH_COUNT)
					pat = font_rows[g*FONT_ROWS + r - 1];
				for (int c = 0; c < CELL_WIDTH; c++) begin
					off = base + r*LINE_STRIDE + c;
					p.offset = off[OFFSET_W-1:0];
					p.value  = pat[CELL_WIDTH-1-c] ? fg_color : bg_color;
					p.last   = (r == CELL_HEIGHT-1 && c == CELL_WIDTH-1);
					pixel_writes_q.push_back(p);
				end
			end
		end
		// every other byte advances the column
		if (int'(cursor_col) + 1 > int'(last_col))
			next_line();
		else
			cursor_col = cursor_col + COL_W'(1);
	endfunction

	// add a request to the pending list, tracking which glyphs are fully loaded
	function automatic void queue_request(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
			input logic [GLYPH_W-1:0] gn, input logic [GROW_W-1:0] gr,
			input logic [GLYPH_BITS-1:0] bits);
		glyph_req_t q;
		q.command          = cmd;
		q.char_code        = ch;
		q.glyph_number     = gn;
		q.glyph_row_number = gr;
		q.row_bits         = bits;
		request_q.push_back(q);
		queued_total++;
		if (cmd == CMD_LOAD && int'(gn) < GLYPH_COUNT && int'(gr) < FONT_ROWS) begin
			gen_rows_loaded[gn][gr] = 1'b1;
			if (&gen_rows_loaded[gn] && !gen_glyph_ready[gn]) begin
				gen_glyph_ready[gn] = 1'b1;
				ready_glyphs.push_back(int'(gn));
			end
		end
	endfunction

	// draw request with random unused load fields
	function automatic void queue_draw(input logic [CHAR_W-1:0] ch);
		queue_request(CMD_DRAW, ch, GLYPH_W'($urandom_range(127)),
			GROW_W'($urandom_range(15)), GLYPH_BITS'($urandom_range(63)));
	endfunction

	// load request with a random unused character field
	function automatic void queue_load(input logic [GLYPH_W-1:0] gn,
			input logic [GROW_W-1:0] gr, input logic [GLYPH_BITS-1:0] bits);
		queue_request(CMD_LOAD, CHAR_W'($urandom_range(255)), gn, gr, bits);
	endfunction

	// all rows of one glyph with random bits
	function automatic void queue_glyph(input int g);
		for (int r = 0; r < FONT_ROWS; r++)
			queue_load(GLYPH_W'(g), GROW_W'(r), GLYPH_BITS'($urandom_range(63)));
	endfunction

	// mostly font loads followed by text from loaded glyphs, some noise
	function automatic void queue_random(input int n);
		int stop;
		int pick;
		stop = queued_total + n;
		while (queued_total < stop) begin
			pick = $urandom_range(99);
			if (ready_glyphs.size() < 3 || pick < 12)
				queue_glyph($urandom_range(GLYPH_COUNT-1));
			else if (pick < 62)
				queue_draw(CHAR_W'(int'(CH_FIRST) +
					ready_glyphs[$urandom_range(ready_glyphs.size()-1)]));
			else if (pick < 74)
				queue_draw($urandom_range(1) ? CH_NEWLINE : CH_RETURN);
			else if (pick < 88)
				queue_draw(CHAR_W'($urandom_range(1) ? $urandom_range(31) :
					$urandom_range(255, 127)));
			else
				queue_load(GLYPH_W'($urandom_range(127)), GROW_W'($urandom_range(15)),
					GLYPH_BITS'($urandom_range(63)));
		end
	endfunction

	// register write while the block is idle, predictor follows on acceptance
	task automatic write_reg(input cfg_reg_t idx, input logic [COLOR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_FOREGROUND:  fg_color = val;
			REG_BACKGROUND:  bg_color = val;
			REG_LAST_COLUMN: last_col = val[COL_W-1:0];
			REG_LAST_ROW:    last_row = val[ROW_W-1:0];
			default: ;
		endcase
	endtask

	// wait until every request is taken and every pixel write has arrived,
	// sampled between edges so the clocked processes have settled
	task automatic drain();
		@(posedge clk);
		while (request_q.size() != 0 || req_valid || pixel_writes_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				render_request(offered);
			if (!req_valid || !req_stall) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = request_q.pop_front();
					command          <= offered.command;
					char_code        <= offered.char_code;
					glyph_number     <= offered.glyph_number;
					glyph_row_number <= offered.glyph_row_number;
					row_bits         <= offered.row_bits;
					req_valid        <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor and receiver stall
	always @(posedge clk) begin
		pixel_write_t want;
		if (arst_n) begin
			if (pix_valid && !pix_stall) begin
				if (pixel_writes_q.size() == 0) begin
					$error("unexpected pixel write: offset %0d value %h", pixel_offset, pixel_value);
					fail_count++;
				end else begin
					want = pixel_writes_q.pop_front();
					if (pixel_offset !== want.offset) begin
						$error("pixel_offset: expected %0d, got %0d", want.offset, pixel_offset);
						fail_count++;
					end
					if (pixel_value !== want.value) begin
						$error("pixel_value: expected %h, got %h", want.value, pixel_value);
						fail_count++;
					end
					if (last_pixel !== want.last) begin
						$error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
						fail_count++;
					end
				end
			end
			// one long hold-off in the pressure phase, else random stalls
			if (hold_left != 0) begin
				pix_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (pressure_on && !hold_done) begin
				pix_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				pix_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("text_console_glyph_renderer regression: fail");
			$finish;
		end
	end

	// phase sequencing
	initial begin
		logic [GLYPH_BITS-1:0] tilde_rows [FONT_ROWS];
		tilde_rows = '{6'h3F, 6'h00, 6'h21, 6'h1E, 6'h2A, 6'h15, 6'h01, 6'h20, 6'h3F};
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed: tilde glyph, ignored loads, edges of the printable range, control bytes
		for (int r = 0; r < FONT_ROWS; r++)
			queue_load(GLYPH_W'(GLYPH_COUNT-1), GROW_W'(r), tilde_rows[r]);
		queue_load(GLYPH_W'(GLYPH_COUNT), GROW_W'(0), 6'h3F);
		queue_load(7'h7F, 4'hF, 6'h3F);
		queue_load(GLYPH_W'(0), GROW_W'(FONT_ROWS), 6'h2A);
		queue_load(GLYPH_W'(GLYPH_COUNT-1), GROW_W'(FONT_ROWS), 6'h00);
		queue_draw(CH_LAST);
		queue_draw(8'h00);
		queue_draw(8'hFF);
		queue_draw(CH_LAST + CHAR_W'(1));
		queue_draw(CH_FIRST - CHAR_W'(1));
		queue_draw(CH_NEWLINE);
		queue_draw(CH_RETURN);
		queue_draw(CH_LAST);
		drain();

		// single-cell screen: every byte that advances the column wraps, row stays at zero
		write_reg(REG_FOREGROUND, COLOR_W'($urandom_range(16'hFFFF)));
		write_reg(REG_BACKGROUND, COLOR_W'($urandom_range(16'hFFFF)));
		write_reg(REG_LAST_COLUMN, COLOR_W'(0));
		write_reg(REG_LAST_ROW, COLOR_W'(0));
		cfg_valid <= 1'b0;
		queue_glyph(0);
		queue_draw(CH_FIRST);
		queue_random(25);
		drain();

		// full screen, extreme colours, sender idling
		write_reg(REG_FOREGROUND, 16'h0000);
		write_reg(REG_BACKGROUND, 16'hFFFF);
		write_reg(REG_LAST_COLUMN, COLOR_W'(LAST_COL_RESET));
		write_reg(REG_LAST_ROW, COLOR_W'(LAST_ROW_RESET));
		cfg_valid <= 1'b0;
		send_idle_pct = 58;
		for (int k = 0; k < 8; k++)
			queue_draw(CH_NEWLINE);
		queue_random(30);
		drain();

		// tiny window below the cursor, receiver stalling
		write_reg(REG_FOREGROUND, COLOR_W'($urandom_range(16'hFFFF)));
		write_reg(REG_BACKGROUND, COLOR_W'($urandom_range(16'hFFFF)));
		write_reg(REG_LAST_COLUMN, COLOR_W'(3));
		write_reg(REG_LAST_ROW, COLOR_W'(2));
		cfg_valid <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 58;
		queue_random(30);
		drain();

		// random window, both sides idling
		write_reg(REG_FOREGROUND, FG_RESET);
		write_reg(REG_BACKGROUND, BG_RESET);
		write_reg(REG_LAST_COLUMN, COLOR_W'($urandom_range(int'(LAST_COL_RESET))));
		write_reg(REG_LAST_ROW, COLOR_W'($urandom_range(int'(LAST_ROW_RESET))));
		cfg_valid <= 1'b0;
		send_idle_pct = 26;
		stall_pct = 26;
		queue_random(30);
		drain();

		// back-pressure: receiver holds off while text keeps coming
		send_idle_pct = 0;
		pressure_on = 1'b1;
		for (int k = 0; k < 20; k++)
			queue_draw(CHAR_W'(int'(CH_FIRST) +
				ready_glyphs[$urandom_range(ready_glyphs.size()-1)]));
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pixel_writes_q.size() == 0 && request_q.size() == 0)
			$display("text_console_glyph_renderer regression: pass");
		else
			$display("text_console_glyph_renderer regression: fail");
		$finish;
	end

endmodule
